[sv/handheld_console_memory_bus_decoder_macros.svh]
// assertion macros for the memory bus decoder
`ifndef HANDHELD_CONSOLE_MEMORY_BUS_DECODER_MACROS_SVH
`define HANDHELD_CONSOLE_MEMORY_BUS_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
`define HCMBD_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("hcmbd same-cycle check failed");
`define HCMBD_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("hcmbd next-cycle check failed");
`else
`define HCMBD_ASSERT_IMP(label, clk, rst_n, pre, post)
`define HCMBD_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

[sv/hcmbd_pkg.sv]
// types, constants and address decode for the memory bus decoder
package hcmbd_pkg;

	localparam int unsigned WRAM_DEPTH = 8192;
	localparam int unsigned WRAM_AW = $clog2(WRAM_DEPTH);
	localparam int unsigned HRAM_DEPTH = 127;
	localparam int unsigned HRAM_AW = $clog2(HRAM_DEPTH);

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_INTERNAL = 3'd1;
	localparam logic [2:0] TGT_CART = 3'd2;
	localparam logic [2:0] TGT_SERIAL = 3'd3;
	localparam logic [2:0] TGT_TIMER = 3'd4;
	localparam logic [2:0] TGT_VIDEO = 3'd5;
	localparam logic [2:0] TGT_JOYPAD = 3'd6;

	localparam logic [7:0] DMA_DELAY = 8'd160;
	localparam logic [4:0] IRQ_EN_MASK = 5'h1F;
	localparam logic [7:0] SCANLINE_FIXED = 8'h90;
	localparam logic [7:0] HRAM_RESET = 8'hFF;

	localparam logic [15:0] ADDR_WRAM_LO = 16'hC000;
	localparam logic [15:0] ADDR_ECHO_HI = 16'hFDFF;
	localparam logic [15:0] ADDR_HRAM_LO = 16'hFF80;
	localparam logic [15:0] ADDR_HRAM_HI = 16'hFFFE;
	localparam logic [15:0] ADDR_LY = 16'hFF44;
	localparam logic [15:0] ADDR_DMA = 16'hFF46;
	localparam logic [15:0] ADDR_IF = 16'hFF0F;
	localparam logic [15:0] ADDR_IE = 16'hFFFF;

	function automatic logic [2:0] region_of(input logic [15:0] a);
		logic [2:0] t;
		if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) begin
			t = TGT_CART;
		end else if (a >= 16'h8000 && a <= 16'h9FFF) begin
			t = TGT_VIDEO;
		end else if (a >= ADDR_WRAM_LO && a <= ADDR_ECHO_HI) begin
			t = TGT_INTERNAL;
		end else if (a >= 16'hFE00 && a <= 16'hFE9F) begin
			t = TGT_VIDEO;
		end else if (a >= 16'hFEA0 && a <= 16'hFEFF) begin
			t = TGT_NONE;
		end else if (a == 16'hFF00) begin
			t = TGT_JOYPAD;
		end else if (a == 16'hFF01 || a == 16'hFF02) begin
			t = TGT_SERIAL;
		end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
			t = TGT_TIMER;
		end else if (a == ADDR_IF) begin
			t = TGT_INTERNAL;
		end else if (a >= 16'hFF40 && a <= 16'hFF4B) begin
			t = TGT_VIDEO;
		end else if (a >= ADDR_HRAM_LO) begin
			t = TGT_INTERNAL;
		end else begin
			t = TGT_NONE;
		end
		return t;
	endfunction

endpackage

[sv/handheld_console_memory_bus_decoder.sv]
// memory bus decoder top level: map decode, work ram, high ram, interrupt and transfer registers
//
// channel  direction  handshake                  payload
// in       input      in_valid / in_stall        op, addr, wdata
// out      output     out_valid / out_stall      target, dev_addr, dev_write, dev_wdata,
//                                                rdata, dma_fire, dma_source_page
// cfg      input      cfg_valid / cfg_ready      cfg_data
//
// one transaction per cycle while in_stall is low; each goes through both stages to the result
// the first stage does the ram access (registered read port), the second is the result register
// after reset a clearing pass zeroes work ram, one entry a cycle, with in_stall high
// out_stall backs up through both stages into in_stall; cfg writes are taken in every cycle
`include "handheld_console_memory_bus_decoder_macros.svh"

module handheld_console_memory_bus_decoder
	import hcmbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] addr,
	input  logic [7:0]  wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  target,
	output logic [15:0] dev_addr,
	output logic        dev_write,
	output logic [7:0]  dev_wdata,
	output logic [7:0]  rdata,
	output logic        dma_fire,
	output logic [7:0]  dma_source_page,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	typedef enum logic [1:0] {
		RS_REG,
		RS_WRAM,
		RS_HRAM
	} rsel_t;

	logic [7:0] wram [WRAM_DEPTH];
	logic [7:0] hram [HRAM_DEPTH];
	logic [HRAM_DEPTH-1:0] hram_vld_q;

	logic               clearing_q;
	logic [WRAM_AW-1:0] clr_cnt_q;
	logic               fixed_mode_q;
	logic [4:0]         irq_en_q;
	logic [7:0]         irq_flags_q;
	logic [7:0]         dma_cnt_q;
	logic [7:0]         xfer_page_q;

	logic               s1_valid_q;
	logic [2:0]         target_s1;
	logic [15:0]        dev_addr_s1;
	logic               dev_write_s1;
	logic [7:0]         dev_wdata_s1;
	rsel_t              rsel_s1;
	logic [7:0]         rval_s1;
	logic [7:0]         wram_rd_s1;
	logic [7:0]         hram_rd_s1;
	logic               hram_vld_s1;
	logic               fire_s1;
	logic [7:0]         page_s1;

	logic               s2_valid_q;
	logic [2:0]         target_s2;
	logic [15:0]        dev_addr_s2;
	logic               dev_write_s2;
	logic [7:0]         dev_wdata_s2;
	logic [7:0]         rdata_s2;
	logic               fire_s2;
	logic [7:0]         page_s2;

	logic               accept;
	logic               s1_adv;
	logic               out_hold;
	logic [WRAM_AW-1:0] wram_idx;
	logic [HRAM_AW-1:0] hram_idx;
	logic               in_wram;
	logic               in_hram;
	logic [2:0]         region;

	logic [2:0]         nx_target;
	logic [15:0]        nx_daddr;
	logic               nx_dwr;
	logic [7:0]         nx_dwd;
	rsel_t              nx_rsel;
	logic [7:0]         nx_rval;
	logic               nx_fire;
	logic [7:0]         nx_page;
	logic               wram_we;
	logic               hram_we;
	logic               irq_flags_we;
	logic               irq_en_we;
	logic               dma_arm;
	logic               dma_dec;

	assign out_hold = s2_valid_q & out_stall;
	assign s1_adv = s1_valid_q & ~out_hold;
	assign in_stall = clearing_q | (s1_valid_q & out_hold);
	assign accept = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	assign wram_idx = addr[WRAM_AW-1:0];
	assign hram_idx = addr[HRAM_AW-1:0];
	assign in_wram = (addr >= ADDR_WRAM_LO) && (addr <= ADDR_ECHO_HI);
	assign in_hram = (addr >= ADDR_HRAM_LO) && (addr <= ADDR_HRAM_HI);
	assign region = region_of(addr);

	always_comb begin
		nx_target = TGT_NONE;
		nx_daddr = '0;
		nx_dwr = 1'b0;
		nx_dwd = '0;
		nx_rsel = RS_REG;
		nx_rval = '0;
		nx_fire = 1'b0;
		nx_page = '0;
		wram_we = 1'b0;
		hram_we = 1'b0;
		irq_flags_we = 1'b0;
		irq_en_we = 1'b0;
		dma_arm = 1'b0;
		dma_dec = 1'b0;
		case (op)
			OP_READ: begin
				if (fixed_mode_q && addr == ADDR_LY) begin
					nx_target = TGT_INTERNAL;
					nx_rval = SCANLINE_FIXED;
				end else begin
					nx_target = region;
					if (region == TGT_INTERNAL) begin
						if (in_wram) begin
							nx_rsel = RS_WRAM;
						end else if (in_hram) begin
							nx_rsel = RS_HRAM;
						end else if (addr == ADDR_IF) begin
							nx_rval = irq_flags_q;
						end else begin
							nx_rval = {3'b000, irq_en_q};
						end
					end else if (region != TGT_NONE) begin
						nx_daddr = addr;
					end
				end
			end
			OP_WRITE: begin
				dma_arm = (addr == ADDR_DMA);
				nx_target = region;
				if (region == TGT_INTERNAL) begin
					wram_we = in_wram;
					hram_we = in_hram;
					irq_flags_we = (addr == ADDR_IF);
					irq_en_we = (addr == ADDR_IE);
				end else if (region != TGT_NONE) begin
					nx_daddr = addr;
					nx_dwr = 1'b1;
					nx_dwd = wdata;
				end
			end
			OP_TICK: begin
				if (dma_cnt_q != 8'd0) begin
					dma_dec = 1'b1;
					if (dma_cnt_q == 8'd1) begin
						nx_fire = 1'b1;
						nx_page = xfer_page_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// work ram, cleared after reset
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			wram[clr_cnt_q] <= 8'h00;
		end else if (accept && wram_we) begin
			wram[wram_idx] <= wdata;
		end
		if (accept) begin
			wram_rd_s1 <= wram[wram_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hram_we) begin
			hram[hram_idx] <= wdata;
		end
		if (accept) begin
			hram_rd_s1 <= hram[hram_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q <= '0;
			fixed_mode_q <= 1'b0;
			irq_en_q <= '0;
			irq_flags_q <= '0;
			dma_cnt_q <= '0;
			xfer_page_q <= '0;
			hram_vld_q <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == WRAM_AW'(WRAM_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				fixed_mode_q <= cfg_data;
			end
			if (accept) begin
				if (hram_we) begin
					hram_vld_q[hram_idx] <= 1'b1;
				end
				if (irq_flags_we) begin
					irq_flags_q <= wdata;
				end
				if (irq_en_we) begin
					irq_en_q <= wdata[4:0] & IRQ_EN_MASK;
				end
				if (dma_arm) begin
					dma_cnt_q <= DMA_DELAY;
					xfer_page_q <= wdata;
				end else if (dma_dec) begin
					dma_cnt_q <= dma_cnt_q - 8'd1;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (!out_stall) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_s1 <= nx_target;
			dev_addr_s1 <= nx_daddr;
			dev_write_s1 <= nx_dwr;
			dev_wdata_s1 <= nx_dwd;
			rsel_s1 <= nx_rsel;
			rval_s1 <= nx_rval;
			hram_vld_s1 <= hram_vld_q[hram_idx];
			fire_s1 <= nx_fire;
			page_s1 <= nx_page;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			target_s2 <= target_s1;
			dev_addr_s2 <= dev_addr_s1;
			dev_write_s2 <= dev_write_s1;
			dev_wdata_s2 <= dev_wdata_s1;
			fire_s2 <= fire_s1;
			page_s2 <= page_s1;
			case (rsel_s1)
				RS_WRAM: rdata_s2 <= wram_rd_s1;
				RS_HRAM: rdata_s2 <= hram_vld_s1 ? hram_rd_s1 : HRAM_RESET;
				default: rdata_s2 <= rval_s1;
			endcase
		end
	end

	assign out_valid = s2_valid_q;
	assign target = target_s2;
	assign dev_addr = dev_addr_s2;
	assign dev_write = dev_write_s2;
	assign dev_wdata = dev_wdata_s2;
	assign rdata = rdata_s2;
	assign dma_fire = fire_s2;
	assign dma_source_page = page_s2;

	`HCMBD_ASSERT_IMP(a_fire_is_quiet, clk, arst_n, out_valid && dma_fire, target == TGT_NONE && rdata == 8'h00 && !dev_write)
	`HCMBD_ASSERT_IMP(a_dev_write_external, clk, arst_n, out_valid && dev_write, target != TGT_NONE && target != TGT_INTERNAL)
	`HCMBD_ASSERT_NXT(a_s1_holds_on_stall, clk, arst_n, s1_valid_q && out_valid && out_stall, s1_valid_q)
	`HCMBD_ASSERT_IMP(a_dma_cnt_bound, clk, arst_n, 1'b1, dma_cnt_q <= DMA_DELAY)

endmodule
